[rtl/psc_pkg.sv]
// shared types, codes and constants of the pressure sensor compensation block
package psc_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_SENSITIVITY  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_OFFSET       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENS_TEMP_COEFF       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_TEMP_COEFF        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFERENCE_TEMPERATURE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMPERATURE_COEFF     = 3'd5;

   // temperature bands of the second-order correction
   localparam logic [1:0] BAND_HIGH     = 2'd0;
   localparam logic [1:0] BAND_LOW      = 2'd1;
   localparam logic [1:0] BAND_VERY_LOW = 2'd2;

   // default depth of the queue between front and back
   localparam int PSC_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [23:0] d1_raw;
      logic [23:0] d2_raw;
   } psc_req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] pressure_tenth_mbar;
   } psc_rsp_type;

   typedef struct packed {
      logic [15:0] pressure_sensitivity;
      logic [15:0] pressure_offset;
      logic [15:0] sens_temp_coeff;
      logic [15:0] off_temp_coeff;
      logic [15:0] reference_temperature;
      logic [15:0] temperature_coeff;
   } psc_cal_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        [23:0] d1;
      logic signed [19:0] temp;
      logic        [16:0] ti;
      logic signed [33:0] sens;
      logic signed [34:0] off;
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic        [1:0]  band;
   } psc_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } psc_queue_status_type;

endpackage

[rtl/psc_front.sv]
// front pipeline: first-order temperature, sensitivity, offset and band classification
module psc_front
   import psc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         start,
   input  psc_req_type  req_payload,
   input  psc_cal_type  cal,
   output psc_item_type item,
   output logic         item_valid
);

   // stage 1
   logic               f1_valid_ff;
   logic        [23:0] f1_d1_ff;
   logic signed [24:0] f1_dt_ff, f1_dt_in;
   // stage 2
   logic               f2_valid_ff;
   logic        [23:0] f2_d1_ff;
   logic signed [41:0] f2_p3_ff, f2_p3_in;
   logic signed [41:0] f2_p4_ff, f2_p4_in;
   logic signed [41:0] f2_p6_ff, f2_p6_in;
   logic        [47:0] f2_dtsq_ff, f2_dtsq_in;
   logic signed [49:0] dtsq_full;
   // stage 3
   logic               f3_valid_ff;
   logic        [23:0] f3_d1_ff;
   logic signed [19:0] f3_x_ff, f3_x_in;
   logic signed [33:0] f3_s3_ff, f3_s3_in;
   logic signed [34:0] f3_s4_ff, f3_s4_in;
   logic        [16:0] f3_ti_low_ff, f3_ti_low_in;
   logic        [16:0] f3_ti_high_ff, f3_ti_high_in;
   logic signed [41:0] p3_biased, p4_biased, p6_biased;
   logic signed [41:0] q3, q4, q6;
   logic        [49:0] dtsq_x3;
   // stage 4
   logic               f4_valid_ff;
   psc_item_type       f4_item_ff, f4_item_in;

   assign f1_dt_in = $signed({1'b0, req_payload.d2_raw})
                   - $signed({1'b0, cal.reference_temperature, 8'h00});

   assign f2_p3_in   = $signed({1'b0, cal.sens_temp_coeff}) * f1_dt_ff;
   assign f2_p4_in   = $signed({1'b0, cal.off_temp_coeff}) * f1_dt_ff;
   assign f2_p6_in   = $signed({1'b0, cal.temperature_coeff}) * f1_dt_ff;
   assign dtsq_full  = f1_dt_ff * f1_dt_ff;
   assign f2_dtsq_in = dtsq_full[47:0];

   // divisions by powers of two truncate toward zero: bias negatives first
   assign p3_biased = f2_p3_ff + $signed({34'b0, {8{f2_p3_ff[41]}}});
   assign p4_biased = f2_p4_ff + $signed({35'b0, {7{f2_p4_ff[41]}}});
   assign p6_biased = f2_p6_ff + $signed({19'b0, {23{f2_p6_ff[41]}}});
   assign q3 = p3_biased >>> 8;
   assign q4 = p4_biased >>> 7;
   assign q6 = p6_biased >>> 23;
   assign f3_s3_in = q3[33:0];
   assign f3_s4_in = q4[34:0];
   // x is temp - 2000
   assign f3_x_in  = q6[19:0];
   assign dtsq_x3       = {2'b0, f2_dtsq_ff} + {1'b0, f2_dtsq_ff, 1'b0};
   assign f3_ti_low_in  = dtsq_x3[49:33];
   assign f3_ti_high_in = {5'b0, f2_dtsq_ff[47:36]};

   always_comb begin
      f4_item_in.d1   = f3_d1_ff;
      f4_item_in.x    = f3_x_ff;
      f4_item_in.temp = f3_x_ff + 20'sd2000;
      f4_item_in.y    = f3_x_ff + 20'sd3500;
      f4_item_in.sens = $signed({3'b0, cal.pressure_sensitivity, 15'b0}) + f3_s3_ff;
      f4_item_in.off  = $signed({3'b0, cal.pressure_offset, 16'b0}) + f3_s4_ff;
      priority if (!f3_x_ff[19]) begin
         f4_item_in.band = BAND_HIGH;
      end else if (f3_x_ff < -20'sd3500) begin
         f4_item_in.band = BAND_VERY_LOW;
      end else begin
         f4_item_in.band = BAND_LOW;
      end
      f4_item_in.ti = f3_x_ff[19] ? f3_ti_low_ff : f3_ti_high_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= start;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_d1_ff      <= req_payload.d1_raw;
         f1_dt_ff      <= f1_dt_in;
         f2_d1_ff      <= f1_d1_ff;
         f2_p3_ff      <= f2_p3_in;
         f2_p4_ff      <= f2_p4_in;
         f2_p6_ff      <= f2_p6_in;
         f2_dtsq_ff    <= f2_dtsq_in;
         f3_d1_ff      <= f2_d1_ff;
         f3_x_ff       <= f3_x_in;
         f3_s3_ff      <= f3_s3_in;
         f3_s4_ff      <= f3_s4_in;
         f3_ti_low_ff  <= f3_ti_low_in;
         f3_ti_high_ff <= f3_ti_high_in;
         f4_item_ff    <= f4_item_in;
      end
   end

   assign item       = f4_item_ff;
   assign item_valid = f4_valid_ff & advance;

endmodule

[rtl/psc_queue.sv]
// small flop-based queue between the front and back pipelines
module psc_queue
   import psc_pkg::*;
#(
   parameter int DEPTH = PSC_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psc_item_type         push_item,
   input  logic                 pop,
   output psc_item_type         pop_item,
   output psc_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   psc_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue pop while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

[rtl/psc_back.sv]
// back pipeline: second-order band correction and final pressure
module psc_back
   import psc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  psc_item_type item,
   output logic         rsp_valid,
   output psc_rsp_type  rsp_payload
);

   localparam int STAGES = 9;

   logic [STAGES-1:0] valid_ff;

   // b1: squares
   psc_item_type       b1_item_ff;
   logic        [31:0] b1_xx_ff, b1_yy_ff;
   logic signed [39:0] xx_full, yy_full;
   // b2: scaled squares
   logic        [23:0] b2_d1_ff;
   logic signed [19:0] b2_temp_ff;
   logic        [16:0] b2_ti_ff;
   logic signed [33:0] b2_sens_ff;
   logic signed [34:0] b2_off_ff;
   logic        [1:0]  b2_band_ff;
   logic        [31:0] b2_t1_ff, b2_t3_ff, b2_t5_ff, b2_t7_ff, b2_t4_ff;
   // b3: band corrections
   logic        [23:0] b3_d1_ff;
   logic signed [33:0] b3_sens_ff;
   logic signed [34:0] b3_off_ff;
   logic signed [31:0] b3_offi_ff, b3_offi_in;
   logic signed [31:0] b3_sensi_ff, b3_sensi_in;
   logic signed [31:0] b3_temp_ff, b3_temp_in;
   logic signed [31:0] t1s, t3s, t5s, div16, div2, div8;
   // b4: corrected sensitivity and offset
   logic        [23:0] b4_d1_ff;
   logic signed [31:0] b4_temp_ff;
   logic signed [34:0] b4_sens2_ff;
   logic signed [35:0] b4_off2_ff;
   // b5: partial products
   logic signed [31:0] b5_temp_ff;
   logic signed [35:0] b5_off2_ff;
   logic        [41:0] b5_plo_ff;
   logic signed [41:0] b5_phi_ff;
   // b6: full product
   logic signed [31:0] b6_temp_ff;
   logic signed [35:0] b6_off2_ff;
   logic signed [58:0] b6_prod_ff;
   // b7: product scaled down
   logic signed [31:0] b7_temp_ff;
   logic signed [35:0] b7_off2_ff;
   logic signed [37:0] b7_q_ff;
   logic signed [58:0] prod_biased, prod_shift;
   // b8: offset removed
   logic signed [31:0] b8_temp_ff;
   logic signed [38:0] b8_diff_ff;
   // b9: output
   logic signed [38:0] diff_biased, diff_shift;
   psc_rsp_type        b9_rsp_ff, b9_rsp_in;

   assign xx_full = item.x * item.x;
   assign yy_full = item.y * item.y;

   // truncating divisions of the wrapped 32-bit corrections
   assign t1s   = b2_t1_ff;
   assign t3s   = b2_t3_ff;
   assign t5s   = b2_t5_ff;
   assign div16 = (t1s + $signed({28'b0, {4{t1s[31]}}})) >>> 4;
   assign div2  = (t3s + $signed({31'b0, t3s[31]})) >>> 1;
   assign div8  = (t5s + $signed({29'b0, {3{t5s[31]}}})) >>> 3;

   always_comb begin
      unique case (b2_band_ff)
         BAND_HIGH: begin
            b3_offi_in  = div16;
            b3_sensi_in = '0;
         end
         BAND_LOW: begin
            b3_offi_in  = div2;
            b3_sensi_in = div8;
         end
         BAND_VERY_LOW: begin
            b3_offi_in  = div2 + $signed(b2_t7_ff);
            b3_sensi_in = div8 + $signed(b2_t4_ff);
         end
         default: begin
            b3_offi_in  = '0;
            b3_sensi_in = '0;
         end
      endcase
      b3_temp_in = $signed({{12{b2_temp_ff[19]}}, b2_temp_ff}) - $signed({15'b0, b2_ti_ff});
   end

   assign prod_biased = b6_prod_ff + $signed({38'b0, {21{b6_prod_ff[58]}}});
   assign prod_shift  = prod_biased >>> 21;
   assign diff_biased = b8_diff_ff + $signed({26'b0, {13{b8_diff_ff[38]}}});
   assign diff_shift  = diff_biased >>> 13;

   always_comb begin
      b9_rsp_in.temperature_centi   = b8_temp_ff;
      b9_rsp_in.pressure_tenth_mbar = $signed({{6{diff_shift[25]}}, diff_shift[25:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], item_valid};
      end
   end

   always_ff @(posedge clock) begin
      b1_item_ff  <= item;
      b1_xx_ff    <= xx_full[31:0];
      b1_yy_ff    <= yy_full[31:0];

      b2_d1_ff    <= b1_item_ff.d1;
      b2_temp_ff  <= b1_item_ff.temp;
      b2_ti_ff    <= b1_item_ff.ti;
      b2_sens_ff  <= b1_item_ff.sens;
      b2_off_ff   <= b1_item_ff.off;
      b2_band_ff  <= b1_item_ff.band;
      b2_t1_ff    <= b1_xx_ff;
      b2_t3_ff    <= b1_xx_ff + {b1_xx_ff[30:0], 1'b0};
      b2_t5_ff    <= b1_xx_ff + {b1_xx_ff[29:0], 2'b0};
      b2_t7_ff    <= {b1_yy_ff[28:0], 3'b0} - b1_yy_ff;
      b2_t4_ff    <= {b1_yy_ff[29:0], 2'b0};

      b3_d1_ff    <= b2_d1_ff;
      b3_sens_ff  <= b2_sens_ff;
      b3_off_ff   <= b2_off_ff;
      b3_offi_ff  <= b3_offi_in;
      b3_sensi_ff <= b3_sensi_in;
      b3_temp_ff  <= b3_temp_in;

      b4_d1_ff    <= b3_d1_ff;
      b4_temp_ff  <= b3_temp_ff;
      b4_sens2_ff <= $signed({b3_sens_ff[33], b3_sens_ff})
                   - $signed({{3{b3_sensi_ff[31]}}, b3_sensi_ff});
      b4_off2_ff  <= $signed({b3_off_ff[34], b3_off_ff})
                   - $signed({{4{b3_offi_ff[31]}}, b3_offi_ff});

      // d1 times sens2 split at bit 18 into two narrow products
      b5_temp_ff  <= b4_temp_ff;
      b5_off2_ff  <= b4_off2_ff;
      b5_plo_ff   <= {18'b0, b4_d1_ff} * {24'b0, b4_sens2_ff[17:0]};
      b5_phi_ff   <= $signed({1'b0, b4_d1_ff}) * $signed(b4_sens2_ff[34:18]);

      b6_temp_ff  <= b5_temp_ff;
      b6_off2_ff  <= b5_off2_ff;
      b6_prod_ff  <= $signed({b5_phi_ff[40:0], 18'b0}) + $signed({17'b0, b5_plo_ff});

      b7_temp_ff  <= b6_temp_ff;
      b7_off2_ff  <= b6_off2_ff;
      b7_q_ff     <= prod_shift[37:0];

      b8_temp_ff  <= b7_temp_ff;
      b8_diff_ff  <= $signed({b7_q_ff[37], b7_q_ff})
                   - $signed({{3{b7_off2_ff[35]}}, b7_off2_ff});

      b9_rsp_ff   <= b9_rsp_in;
   end

   assign rsp_valid   = valid_ff[STAGES-1];
   assign rsp_payload = b9_rsp_ff;

endmodule

[rtl/pressure_sensor_compensation_top.sv]
// top level of the pressure sensor second-order compensation block
//
//   channel   ports                                         transfer when
//   request   start, busy, req_payload                      start & !busy
//   response  rsp_valid, rsp_payload                        rsp_valid (one cycle)
//   config    csr_write_enable, csr_index, csr_write_data   csr_write_enable
//
// one transfer per clock sustained; the response strobe follows the accepting
// edge through 14 registers: the four front stages, the queue entry and the
// nine back stages, the first of them loaded at the accepting edge itself
// the front computes dt, the first-order terms and the band, the back
// applies the band correction and the split d1 * sens2 product
// reset is synchronous and active high; it clears the calibration words,
// the valid bits and the queue pointers
// the receiver cannot stall and busy stays low: the back takes a queued item
// every cycle, so a full queue always pops at the same edge it is pushed
module pressure_sensor_compensation_top
   import psc_pkg::*;
#(
   parameter int QUEUE_DEPTH = PSC_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   start,
   output logic                   busy,
   input  psc_req_type            req_payload,
   // response
   output logic                   rsp_valid,
   output psc_rsp_type            rsp_payload,
   // configuration
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   psc_cal_type          cal_ff, cal_in;
   psc_item_type         front_item, queue_item;
   logic                 front_valid;
   logic                 advance;
   logic                 pop;
   psc_queue_status_type queue_status;

   // calibration words; writes to unused indexes are dropped
   always_comb begin
      cal_in = cal_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PRESSURE_SENSITIVITY:  cal_in.pressure_sensitivity  = csr_write_data;
            CSR_PRESSURE_OFFSET:       cal_in.pressure_offset       = csr_write_data;
            CSR_SENS_TEMP_COEFF:       cal_in.sens_temp_coeff       = csr_write_data;
            CSR_OFF_TEMP_COEFF:        cal_in.off_temp_coeff        = csr_write_data;
            CSR_REFERENCE_TEMPERATURE: cal_in.reference_temperature = csr_write_data;
            CSR_TEMPERATURE_COEFF:     cal_in.temperature_coeff     = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // the back never stalls, so any queued item leaves every cycle
   assign pop     = !queue_status.empty;
   assign advance = !queue_status.full || pop;
   assign busy    = !advance;

   psc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .start       (start),
      .req_payload (req_payload),
      .cal         (cal_ff),
      .item        (front_item),
      .item_valid  (front_valid)
   );

   psc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (queue_item),
      .status    (queue_status)
   );

   psc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (pop),
      .item        (queue_item),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[dv/pressure_sensor_compensation_top_test.sv]
// self-checking testbench for the pressure sensor second-order compensation block
module pressure_sensor_compensation_top_test;
   import psc_pkg::*;

   // register indexes past the last calibration word, writes there are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // calibration presets used by the directed part
   localparam int CAL_ZERO    = 0;
   localparam int CAL_TYPICAL = 1;
   localparam int CAL_FULL    = 2;

   localparam longint RAW_MAX      = 64'sd16777215;
   localparam int     RANDOM_ROUNDS = 5;
   localparam int     ROUND_PAIRS   = 96;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   psc_req_type            req_payload;
   logic                   rsp_valid;
   psc_rsp_type            rsp_payload;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // calibration words as the block should hold them
   psc_cal_type cal_words;
   // readings still owed by the block, oldest first
   psc_rsp_type pending_readings[$];
   int          mismatch_count = 0;

   // a pair whose reading is written into the table by hand travels with it
   bit          hand_checked;
   psc_rsp_type hand_reading;

   typedef struct {
      int          cal_sel;
      logic [23:0] d1;
      logic [23:0] d2;
      bit          by_hand;
      int          temp_want;
      int          pres_want;
   } probe_row_type;

   psc_cal_type cal_presets [3] = '{
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}
   };

   probe_row_type probe_rows [19] = '{
      // all-zero calibration: dt is d2, temperature only loses the high-band square
      '{CAL_ZERO, 24'h000000, 24'h000000, 1'b1, 2000, 0},
      '{CAL_ZERO, 24'hFFFFFF, 24'h000000, 1'b1, 2000, 0},
      '{CAL_ZERO, 24'hFFFFFF, 24'hFFFFFF, 1'b1, -2095, 0},
      '{CAL_ZERO, 24'h555555, 24'hAAAAAA, 1'b0, 0, 0},
      // typical calibration, d2 walks across the band edges
      '{CAL_TYPICAL, 24'd4311550, 24'd6821376, 1'b0, 0, 0},  // first-order exactly 20 C
      '{CAL_TYPICAL, 24'd4311550, 24'd6821055, 1'b0, 0, 0},  // just into the low band
      '{CAL_TYPICAL, 24'd4311550, 24'd5698442, 1'b0, 0, 0},  // -15 C, still low band
      '{CAL_TYPICAL, 24'd4311550, 24'd5698121, 1'b0, 0, 0},  // just into very low
      '{CAL_TYPICAL, 24'd4311550, 24'd7463056, 1'b0, 0, 0},  // high band
      '{CAL_TYPICAL, 24'd4311550, 24'd6757208, 1'b0, 0, 0},  // low band, first-order 18 C
      '{CAL_TYPICAL, 24'h000000, 24'd8077140, 1'b0, 0, 0},   // zero pressure conversion
      '{CAL_TYPICAL, 24'hFFFFFF, 24'd8077140, 1'b0, 0, 0},
      '{CAL_TYPICAL, 24'd4311550, 24'h000000, 1'b0, 0, 0},   // coldest possible
      '{CAL_TYPICAL, 24'd4311550, 24'hFFFFFF, 1'b0, 0, 0},   // hottest possible
      // full-scale calibration: 32-bit band terms and outputs wrap
      '{CAL_FULL, 24'h000000, 24'h000000, 1'b0, 0, 0},
      '{CAL_FULL, 24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
      '{CAL_FULL, 24'h000000, 24'hFFFFFF, 1'b0, 0, 0},
      '{CAL_FULL, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 0, 0},
      '{CAL_FULL, 24'h800000, 24'h7FFFFF, 1'b0, 0, 0}
   };

   pressure_sensor_compensation_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // k * x * x kept to 32 bits and read back signed
   function automatic longint wrap_square(int unsigned k, longint x);
      int unsigned ux;
      int unsigned p;
      ux = x[31:0];
      p = k * ux * ux;
      return longint'($signed(p));
   endfunction

   // compensated temperature and pressure for one conversion pair
   function automatic psc_rsp_type compensate(psc_req_type r, psc_cal_type c);
      longint d1, dt, sens, off, t, ti, offi, sensi, pres;
      int wa, wb;
      psc_rsp_type o;
      d1 = longint'(r.d1_raw);
      dt = longint'(r.d2_raw) - longint'(c.reference_temperature) * 256;
      sens = longint'(c.pressure_sensitivity) * 32768
           + (longint'(c.sens_temp_coeff) * dt) / 256;
      off = longint'(c.pressure_offset) * 65536
          + (longint'(c.off_temp_coeff) * dt) / 128;
      t = 2000 + (dt * longint'(c.temperature_coeff)) / 8388608;
      if (t < 2000) begin
         ti = (3 * dt * dt) / 64'sd8589934592;
         offi = wrap_square(3, t - 2000) / 2;
         sensi = wrap_square(5, t - 2000) / 8;
         // very low band adds on top of low, the sums wrap at 32 bits
         if (t < -1500) begin
            wa = int'(offi) + int'(wrap_square(7, t + 1500));
            wb = int'(sensi) + int'(wrap_square(4, t + 1500));
            offi = longint'(wa);
            sensi = longint'(wb);
         end
      end else begin
         ti = (2 * dt * dt) / 64'sd137438953472;
         offi = wrap_square(1, t - 2000) / 16;
         sensi = 0;
      end
      t = t - ti;
      pres = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;
      o.temperature_centi = t[31:0];
      o.pressure_tenth_mbar = pres[31:0];
      return o;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic psc_cal_type pick_cal();
      psc_cal_type c;
      c.pressure_sensitivity = pick_word();
      c.pressure_offset = pick_word();
      c.sens_temp_coeff = pick_word();
      c.off_temp_coeff = pick_word();
      c.reference_temperature = pick_word();
      c.temperature_coeff = pick_word();
      return c;
   endfunction

   function automatic logic [23:0] pick_d1();
      case ($urandom_range(0, 9))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   // half of the temperature conversions sit around the reference point so that
   // every band and its edges get hit, the rest sit at either end or spread over it
   function automatic logic [23:0] pick_d2(psc_cal_type c);
      longint centre, spread, v;
      centre = longint'(c.reference_temperature) * 256;
      spread = longint'(1) << $urandom_range(4, 22);
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = RAW_MAX;
         2, 3, 4, 5, 6:
            v = centre - spread + longint'($urandom_range(0, int'(2 * spread)));
         default: v = longint'($urandom_range(0, 24'hFFFFFF));
      endcase
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return v[23:0];
   endfunction

   // one conversion pair, held until the block takes it
   task automatic send_pair(psc_req_type r, bit by_hand, psc_rsp_type want);
      start <= 1'b1;
      req_payload <= r;
      hand_checked = by_hand;
      hand_reading = want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // let every owed reading come out before touching the calibration
   task automatic drain();
      start <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_word(logic [CSR_INDEX_W-1:0] idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic load_cal(psc_cal_type c);
      write_word(CSR_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
      write_word(CSR_PRESSURE_OFFSET, c.pressure_offset);
      write_word(CSR_SENS_TEMP_COEFF, c.sens_temp_coeff);
      write_word(CSR_OFF_TEMP_COEFF, c.off_temp_coeff);
      write_word(CSR_REFERENCE_TEMPERATURE, c.reference_temperature);
      write_word(CSR_TEMPERATURE_COEFF, c.temperature_coeff);
      // a write past the last word must leave the calibration alone
      write_word($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                 16'($urandom_range(0, 16'hFFFF)));
      csr_write_enable <= 1'b0;
   endtask

   // scoreboard: predict on every accepted pair, check every strobed reading
   always @(posedge clock) begin : check_readings
      psc_rsp_type want;
      if (reset) begin
         cal_words = '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PRESSURE_SENSITIVITY:  cal_words.pressure_sensitivity = csr_write_data;
               CSR_PRESSURE_OFFSET:       cal_words.pressure_offset = csr_write_data;
               CSR_SENS_TEMP_COEFF:       cal_words.sens_temp_coeff = csr_write_data;
               CSR_OFF_TEMP_COEFF:        cal_words.off_temp_coeff = csr_write_data;
               CSR_REFERENCE_TEMPERATURE: cal_words.reference_temperature = csr_write_data;
               CSR_TEMPERATURE_COEFF:     cal_words.temperature_coeff = csr_write_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            pending_readings.push_back(hand_checked ? hand_reading
                                                    : compensate(req_payload, cal_words));
         end
         if (rsp_valid) begin
            if (pending_readings.size() == 0) begin
               $display("%0t: reading with none owed: temp %0d pres %0d", $time,
                        rsp_payload.temperature_centi, rsp_payload.pressure_tenth_mbar);
               mismatch_count++;
            end else begin
               want = pending_readings.pop_front();
               if (rsp_payload.temperature_centi !== want.temperature_centi) begin
                  $display("%0t: temperature_centi expected %0d got %0d", $time,
                           want.temperature_centi, rsp_payload.temperature_centi);
                  mismatch_count++;
               end
               if (rsp_payload.pressure_tenth_mbar !== want.pressure_tenth_mbar) begin
                  $display("%0t: pressure_tenth_mbar expected %0d got %0d", $time,
                           want.pressure_tenth_mbar, rsp_payload.pressure_tenth_mbar);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin : drive_pairs
      int applied;
      psc_req_type r;
      psc_rsp_type want;
      hand_checked = 1'b0;
      hand_reading = '0;
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed table, calibration after reset is all zero
      applied = CAL_ZERO;
      foreach (probe_rows[i]) begin
         if (probe_rows[i].cal_sel != applied) begin
            drain();
            load_cal(cal_presets[probe_rows[i].cal_sel]);
            applied = probe_rows[i].cal_sel;
         end
         r.d1_raw = probe_rows[i].d1;
         r.d2_raw = probe_rows[i].d2;
         want.temperature_centi = probe_rows[i].temp_want;
         want.pressure_tenth_mbar = probe_rows[i].pres_want;
         send_pair(r, probe_rows[i].by_hand, want);
         if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
      end

      // random rounds, each under its own calibration; the last has no gaps
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         drain();
         load_cal(round == 0 ? cal_presets[CAL_TYPICAL] : pick_cal());
         for (int n = 0; n < ROUND_PAIRS; n++) begin
            r.d1_raw = pick_d1();
            r.d2_raw = pick_d2(cal_words);
            send_pair(r, 1'b0, '0);
            if (round < RANDOM_ROUNDS - 1 && $urandom_range(0, 3) == 0) begin
               pause($urandom_range(1, 8));
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("pressure_sensor_compensation_top verification clean");
      end else begin
         $display("pressure_sensor_compensation_top verification failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #400000;
      $display("pressure_sensor_compensation_top verification failed");
      $finish;
   end

endmodule
